[hdl/utf8_to_ucs2_decoder_defines.svh]
// Assertion macros shared by the checker of the UTF-8 to UCS-2 decoder.
// Each macro needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef UTF8_TO_UCS2_DECODER_DEFINES_SVH
`define UTF8_TO_UCS2_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define U8U2_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("u8u2 checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define U8U2_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("u8u2 checker: next-cycle property failed");

`endif

[hdl/u8u2_pkg.sv]
// Package for the UTF-8 to UCS-2 decoder: field widths, byte codes and the
// result record passed from the decode core to the output buffer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package u8u2_pkg;

    localparam int BYTE_W = 8;
    localparam int UNIT_W = 16;
    localparam int NUM_W  = 7;
    localparam int OUT_TDATA_W = 24;

    // Lead byte classification masks and patterns.
    localparam logic [7:0] ASCII_MAX   = 8'h7F;
    localparam logic [7:0] MASK_TWO    = 8'hE0;
    localparam logic [7:0] LEAD_TWO    = 8'hC0;
    localparam logic [7:0] MASK_THREE  = 8'hF0;
    localparam logic [7:0] LEAD_THREE  = 8'hE0;
    localparam logic [7:0] LEAD_FOUR   = 8'hF0;

    typedef struct packed {
        logic              valid;
        logic [UNIT_W-1:0] code_unit;
        logic [NUM_W-1:0]  unit_number;
    } t_result;

endpackage

`default_nettype wire

[hdl/u8u2_core.sv]
// Decode core: holds the per-string decode state and turns each accepted byte
// into at most one result record. Depends on u8u2_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8u2_core #(
    parameter int OUT_BUFFER_BYTES = 150
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_accept,
    input  wire logic [u8u2_pkg::BYTE_W-1:0]  i_byte,
    input  wire logic                         i_last,
    output u8u2_pkg::t_result                 o_result
);

    localparam int UNIT_CAP = OUT_BUFFER_BYTES / 2;
    localparam int CNT_W    = $clog2(UNIT_CAP + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(UNIT_CAP);

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_TWO   = 2'd1,
        KIND_THREE = 2'd2,
        KIND_FOUR  = 2'd3
    } t_kind;

    logic [1:0]                  r_pending, n_pending;
    t_kind                       r_kind, n_kind;
    logic [u8u2_pkg::UNIT_W-1:0] r_partial, n_partial;
    logic                        r_stopped, n_stopped;
    logic [CNT_W-1:0]            r_count, n_count;

    logic                        emit_req;
    logic [u8u2_pkg::UNIT_W-1:0] emit_val;
    logic [u8u2_pkg::UNIT_W-1:0] shifted;
    logic [CNT_W+6:0]            count_ext;

    assign shifted   = {r_partial[9:0], i_byte[5:0]};
    assign count_ext = {7'd0, r_count};

    always_comb begin
        n_pending = r_pending;
        n_kind    = r_kind;
        n_partial = r_partial;
        n_stopped = r_stopped;
        n_count   = r_count;
        emit_req  = 1'b0;
        emit_val  = '0;

        if (!r_stopped) begin
            if (r_pending != 2'd0) begin
                n_partial = shifted;
                n_pending = r_pending - 2'd1;
                if (r_pending == 2'd1) begin
                    emit_req  = 1'b1;
                    emit_val  = (r_kind == KIND_FOUR) ? '0 : shifted;
                    n_kind    = KIND_NONE;
                    n_partial = '0;
                end
            end else if (i_byte == '0) begin
                n_stopped = 1'b1;
            end else if (i_byte <= u8u2_pkg::ASCII_MAX) begin
                emit_req = 1'b1;
                emit_val = {8'd0, i_byte};
            end else if ((i_byte & u8u2_pkg::MASK_TWO) == u8u2_pkg::LEAD_TWO) begin
                n_kind    = KIND_TWO;
                n_pending = 2'd1;
                n_partial = {11'd0, i_byte[4:0]};
            end else if ((i_byte & u8u2_pkg::MASK_THREE) == u8u2_pkg::LEAD_THREE) begin
                n_kind    = KIND_THREE;
                n_pending = 2'd2;
                n_partial = {12'd0, i_byte[3:0]};
            end else if ((i_byte & u8u2_pkg::MASK_THREE) == u8u2_pkg::LEAD_FOUR) begin
                n_kind    = KIND_FOUR;
                n_pending = 2'd3;
                n_partial = '0;
            end else begin
                // A continuation byte where a lead byte belongs ends the string.
                n_stopped = 1'b1;
            end
        end

        o_result.valid       = i_accept && emit_req && (r_count < CAP_CNT);
        o_result.code_unit   = emit_val;
        o_result.unit_number = count_ext[6:0];
        if (emit_req && (r_count < CAP_CNT)) begin
            n_count = r_count + CNT_W'(1);
        end

        if (i_last) begin
            n_pending = 2'd0;
            n_kind    = KIND_NONE;
            n_partial = '0;
            n_stopped = 1'b0;
            n_count   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_kind    <= KIND_NONE;
            r_partial <= '0;
            r_stopped <= 1'b0;
            r_count   <= '0;
        end else if (i_accept) begin
            r_pending <= n_pending;
            r_kind    <= n_kind;
            r_partial <= n_partial;
            r_stopped <= n_stopped;
            r_count   <= n_count;
        end
    end

endmodule

`default_nettype wire

[hdl/u8u2_skid.sv]
// Output stage: a result register with one skid entry, so the input side sees a
// registered ready and keeps accepting while a result waits. Depends on u8u2_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8u2_skid (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire u8u2_pkg::t_result                 i_result,
    output logic                                   o_ready,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [u8u2_pkg::OUT_TDATA_W-1:0]       o_m_tdata
);

    logic                     r_out_valid;
    logic                     r_skid_valid;
    u8u2_pkg::t_result        r_out;
    u8u2_pkg::t_result        r_skid;

    assign o_ready    = !r_skid_valid;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out.unit_number, r_out.code_unit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_m_tready) begin
            // The skid entry is older than anything arriving now, and while it is
            // full no new beat can arrive.
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_result.valid;
            end
        end else if (i_result.valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_tready) begin
            r_out <= r_skid_valid ? r_skid : i_result;
        end else if (i_result.valid) begin
            r_skid <= i_result;
        end
    end

endmodule

`default_nettype wire

[hdl/utf8_to_ucs2_decoder.sv]
// UTF-8 to UCS-2 decoder. Upstream beats carry one UTF-8 byte with tlast marking
// the last byte of a string; downstream beats carry one 16-bit code unit and its
// index within the string. Downstream has a result register and a skid entry.
// Input:  s_tdata = in_byte, s_tlast = end_of_string. A beat moves when tvalid and
//         tready are both high at a rising edge of i_clk.
// Output: m_tdata = code_unit, unit_number, one zero pad bit.
// Throughput: one byte per cycle while s_tready is high, set by the per-byte update
//         of the decode state; a completing byte's unit is registered downstream.
// Bytes that only start or continue a character, bytes after a stop and bytes
// beyond the unit cap give no output beat.
// Stall: while the receiver holds m_tready low, one more result fits in the skid
// entry; once it fills, s_tready, which is registered, drops in the next cycle.
// Reset (i_rst_n low, synchronous): decode state and unit count clear, both
// output registers empty, s_tready goes high while reset is still held.
// OUT_BUFFER_BYTES/2 sets the number of units kept per string.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_ucs2_decoder #(
    parameter int OUT_BUFFER_BYTES = 150
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [u8u2_pkg::BYTE_W-1:0]         s_tdata,   // [7:0] in_byte
    input  wire logic                                s_tlast,   // end_of_string
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [u8u2_pkg::OUT_TDATA_W-1:0]         m_tdata    // [15:0] code_unit,
                                                                 // [22:16] unit_number,
                                                                 // [23] zero
);

    logic              accept;
    u8u2_pkg::t_result result;

    assign accept = s_tvalid && s_tready;

    u8u2_core #(
        .OUT_BUFFER_BYTES (OUT_BUFFER_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_tdata),
        .i_last   (s_tlast),
        .o_result (result)
    );

    u8u2_skid u_skid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_result   (result),
        .o_ready    (s_tready),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

[hdl/u8u2_checker.sv]
// Port-level checker for the UTF-8 to UCS-2 decoder, bound to the top level.
// Depends on utf8_to_ucs2_decoder_defines.svh and u8u2_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_to_ucs2_decoder_defines.svh"

module u8u2_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [u8u2_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    // A stalled output beat keeps its payload.
    `U8U2_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // The input side only backs up when a result is already waiting downstream.
    `U8U2_ASSERT_SAME(a_ready_low_has_out, !s_tready, m_tvalid)
    // A full skid entry is empty in the cycle after the receiver takes a beat.
    `U8U2_ASSERT_NEXT(a_skid_drains, !s_tready && m_tready, s_tready)
    // The pad bit above the unit number stays clear.
    `U8U2_ASSERT_SAME(a_pad_zero, m_tvalid, !m_tdata[23])

endmodule

bind utf8_to_ucs2_decoder u8u2_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
